@@ src/stlc_pkg.sv @@
// Shared types and constants for the sustained-threshold light and climate controller.
// Used by stlc_core and sustained_threshold_light_climate_ctrl; no dependencies.
`timescale 1ns / 1ps

package stlc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 3'd5;

    // Register reset values
    localparam logic [7:0]  TEMP_HIGH_RST   = 8'sd35;
    localparam logic [7:0]  TEMP_LOW_RST    = 8'sd10;
    localparam logic [6:0]  HUMID_HIGH_RST  = 7'd80;
    localparam logic [6:0]  HUMID_LOW_RST   = 7'd20;
    localparam logic [15:0] LIGHT_LEVEL_RST = 16'd500;
    localparam logic [15:0] HOLD_MS_RST     = 16'd2000;

    // Day runs from the first hour up to, not including, the end hour
    localparam logic [4:0] DAY_FIRST_HOUR = 5'd6;
    localparam logic [4:0] DAY_END_HOUR   = 5'd18;

    // Configuration as seen by the decision logic
    typedef struct packed {
        logic [7:0]  temp_high;
        logic [7:0]  temp_low;
        logic [6:0]  humid_high;
        logic [6:0]  humid_low;
        logic [15:0] light_level;
        logic [15:0] hold_ms;
    } cfg_t;

    // One control tick
    typedef struct packed {
        logic [31:0] now_ms;
        logic [4:0]  hour;
        logic [7:0]  temperature;
        logic [6:0]  humidity;
        logic [15:0] light;
    } item_t;

    // One result item
    typedef struct packed {
        logic night_lamp;
        logic climate_alarm;
        logic motor_open;
    } result_t;

endpackage

@@ src/stlc_core.sv @@
// Decision logic and timer state of the light and climate controller.
// Depends on stlc_pkg; instantiated by sustained_threshold_light_climate_ctrl.
`timescale 1ns / 1ps

module stlc_core
    import stlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [31:0] climate_start_reg, climate_start_next;
    logic        climate_running_reg, climate_running_next;
    logic [31:0] bright_start_reg, bright_start_next;
    logic        bright_running_reg, bright_running_next;
    logic [31:0] dark_start_reg, dark_start_next;
    logic        dark_running_reg, dark_running_next;
    logic        lamp_state_reg, lamp_state_next;
    logic        alarm_state_reg, alarm_state_next;
    logic        motor_state_reg, motor_state_next;

    logic        bad;
    logic        day;
    logic        above;
    logic        below;
    logic [31:0] climate_elapsed;
    logic [31:0] bright_elapsed;
    logic [31:0] dark_elapsed;
    logic        climate_held;
    logic        bright_held;
    logic        dark_held;

    // Window and threshold compares
    assign bad = ($signed(item.temperature) > $signed(cfg.temp_high))
              || ($signed(item.temperature) < $signed(cfg.temp_low))
              || (item.humidity > cfg.humid_high)
              || (item.humidity < cfg.humid_low);
    assign day   = (item.hour >= DAY_FIRST_HOUR) && (item.hour < DAY_END_HOUR);
    assign above = item.light > cfg.light_level;
    assign below = item.light < cfg.light_level;

    // Elapsed time per timer, modulo 2^32
    assign climate_elapsed = item.now_ms - climate_start_reg;
    assign bright_elapsed  = item.now_ms - bright_start_reg;
    assign dark_elapsed    = item.now_ms - dark_start_reg;
    assign climate_held    = climate_elapsed >= {16'd0, cfg.hold_ms};
    assign bright_held     = bright_elapsed >= {16'd0, cfg.hold_ms};
    assign dark_held       = dark_elapsed >= {16'd0, cfg.hold_ms};

    // Next state for one item
    always_comb
    begin
        climate_start_next   = climate_start_reg;
        climate_running_next = climate_running_reg;
        bright_start_next    = bright_start_reg;
        bright_running_next  = bright_running_reg;
        dark_start_next      = dark_start_reg;
        dark_running_next    = dark_running_reg;
        lamp_state_next      = lamp_state_reg;
        alarm_state_next     = alarm_state_reg;
        motor_state_next     = motor_state_reg;

        // Climate timer: the first out-of-range tick only starts it.
        if (bad)
        begin
            climate_running_next = 1'b1;
            if (!climate_running_reg)
            begin
                climate_start_next = item.now_ms;
            end
            else if (climate_held)
            begin
                alarm_state_next = 1'b1;
            end
        end
        else
        begin
            climate_running_next = 1'b0;
            alarm_state_next     = 1'b0;
        end

        // Light timers: at most one of them runs, and equal light clears both.
        if (day)
        begin
            bright_running_next = above;
            dark_running_next   = below;
            if (above)
            begin
                if (!bright_running_reg)
                begin
                    bright_start_next = item.now_ms;
                end
                else if (bright_held)
                begin
                    motor_state_next = 1'b1;
                end
            end
            if (below)
            begin
                if (!dark_running_reg)
                begin
                    dark_start_next = item.now_ms;
                end
                else if (dark_held)
                begin
                    motor_state_next = 1'b0;
                end
            end
        end
        else
        begin
            lamp_state_next     = below;
            bright_running_next = 1'b0;
            dark_running_next   = 1'b0;
        end
    end

    // The result is the state after this item.
    assign result.night_lamp    = lamp_state_next;
    assign result.climate_alarm = alarm_state_next;
    assign result.motor_open    = motor_state_next;

    // Flag and output state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            climate_running_reg <= 1'b0;
            bright_running_reg  <= 1'b0;
            dark_running_reg    <= 1'b0;
            lamp_state_reg      <= 1'b0;
            alarm_state_reg     <= 1'b0;
            motor_state_reg     <= 1'b0;
            climate_start_reg   <= '0;
            bright_start_reg    <= '0;
            dark_start_reg      <= '0;
        end
        else if (advance)
        begin
            climate_running_reg <= climate_running_next;
            bright_running_reg  <= bright_running_next;
            dark_running_reg    <= dark_running_next;
            lamp_state_reg      <= lamp_state_next;
            alarm_state_reg     <= alarm_state_next;
            motor_state_reg     <= motor_state_next;
            climate_start_reg   <= climate_start_next;
            bright_start_reg    <= bright_start_next;
            dark_start_reg      <= dark_start_next;
        end
    end

    // The alarm can only come on while the climate timer was already running.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(alarm_state_reg) |-> $past(climate_running_reg))
        else $error("alarm set without a running climate timer");

    // Bright and dark timers never run together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(bright_running_reg && dark_running_reg))
        else $error("bright and dark timers both running");

    // The motor only moves on a day item that had a running light timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (motor_state_reg != $past(motor_state_reg)) |->
            ($past(advance) && $past(day)
             && ($past(bright_running_reg) || $past(dark_running_reg))))
        else $error("motor changed outside a held day condition");

endmodule

@@ src/sustained_threshold_light_climate_ctrl.sv @@
// Top level of the sustained-threshold light and climate controller.
// Depends on stlc_pkg and stlc_core.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid/in_ready with now_ms, hour, temperature, humidity
//   and light. Each accepted item is one control tick.
//   Output channel: out_valid/out_ready with night_lamp, climate_alarm and
//   motor_open; exactly one result item per input item, in order.
//   Configuration: wr_en, wr_index and wr_data write one register per cycle
//   (0 temp_high, 1 temp_low, 2 humid_high, 3 humid_low, 4 light_level,
//   5 hold_ms); other indexes are ignored. Write only while the block is idle.
// Timing
//   An item accepted at one edge sits in the input register, is decided by
//   one pass of compares and three 32-bit subtractions, and its result is
//   loaded into the result register when the item moves on, which waits
//   while a held result is not yet taken.
//   One item per cycle is sustained while out_ready stays high; the timer
//   state is updated as each item moves into the result register.
// Reset and stall
//   Reset clears all timers, output state and out_valid; loads register defaults.
//   When out_ready is low the result is held, one further item waits in the
//   input register, and in_ready then drops until the result is taken.

module sustained_threshold_light_climate_ctrl
    import stlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_ms,
    input  logic [4:0]  hour,
    input  logic signed [7:0] temperature,
    input  logic [6:0]  humidity,
    input  logic [15:0] light,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        night_lamp,
    output logic        climate_alarm,
    output logic        motor_open,
    input  logic        wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [15:0] wr_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t result_next;
    logic    advance;

    // An item moves on when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_high   <= TEMP_HIGH_RST;
            cfg_reg.temp_low    <= TEMP_LOW_RST;
            cfg_reg.humid_high  <= HUMID_HIGH_RST;
            cfg_reg.humid_low   <= HUMID_LOW_RST;
            cfg_reg.light_level <= LIGHT_LEVEL_RST;
            cfg_reg.hold_ms     <= HOLD_MS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_TEMP_HIGH:   cfg_reg.temp_high   <= wr_data[7:0];
                CFG_TEMP_LOW:    cfg_reg.temp_low    <= wr_data[7:0];
                CFG_HUMID_HIGH:  cfg_reg.humid_high  <= wr_data[6:0];
                CFG_HUMID_LOW:   cfg_reg.humid_low   <= wr_data[6:0];
                CFG_LIGHT_LEVEL: cfg_reg.light_level <= wr_data;
                CFG_HOLD_MS:     cfg_reg.hold_ms     <= wr_data;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.now_ms      <= now_ms;
            item_reg.hour        <= hour;
            item_reg.temperature <= temperature;
            item_reg.humidity    <= humidity;
            item_reg.light       <= light;
        end
    end

    // Decision logic and timer state
    stlc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign night_lamp    = result_reg.night_lamp;
    assign climate_alarm = result_reg.climate_alarm;
    assign motor_open    = result_reg.motor_open;

    // An accepted item is held in the input register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> item_valid_reg)
        else $error("accepted item lost from input register");

    // A waiting item is not dropped while the result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && out_valid_reg && !out_ready) |=>
            (item_valid_reg && out_valid_reg))
        else $error("item or result dropped under stall");

    // Every item that moves on shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

endmodule

@@ sim/stlc_result_checker.sv @@
// Result checker for the sustained-threshold light and climate controller.
// Watches the config port and both item channels, predicts each result and compares it.
// Depends on stlc_pkg for the configuration, tick and result types.
`timescale 1ns / 1ps

module stlc_result_checker
    import stlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [31:0]          now_ms,
    input  logic [4:0]           hour,
    input  logic signed [7:0]    temperature,
    input  logic [6:0]           humidity,
    input  logic [15:0]          light,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 night_lamp,
    input  logic                 climate_alarm,
    input  logic                 motor_open,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]          wr_data,
    output int unsigned          fail_count,
    output int unsigned          pending
);

    // Local copy of the configuration and of the controller state.
    cfg_t        cfg;
    logic [31:0] climate_t0;
    logic [31:0] bright_t0;
    logic [31:0] dark_t0;
    logic        climate_on;
    logic        bright_on;
    logic        dark_on;
    result_t     ctrl_state;

    // Outputs predicted for ticks that have been accepted but not yet seen.
    result_t     expected_outputs[$];

    item_t       seen_tick;
    result_t     predicted;
    result_t     observed;
    result_t     wanted;

    // True once the hold time has passed since start, with wrapping time.
    function automatic logic hold_elapsed(input logic [31:0] now, input logic [31:0] start);
        logic [31:0] delta;
        delta = now - start;
        return delta >= {16'd0, cfg.hold_ms};
    endfunction

    // Apply one control tick to the local state and return the new outputs.
    task automatic advance_controller(input item_t tick, output result_t res);
        logic out_of_window;
        logic is_day;
        out_of_window = ($signed(tick.temperature) > $signed(cfg.temp_high))
                     || ($signed(tick.temperature) < $signed(cfg.temp_low))
                     || (tick.humidity > cfg.humid_high)
                     || (tick.humidity < cfg.humid_low);
        is_day = (tick.hour >= DAY_FIRST_HOUR) && (tick.hour < DAY_END_HOUR);

        // Climate indicator: sustained out-of-window sets it, in-window clears at once.
        if (out_of_window) begin
            if (!climate_on) begin
                climate_on = 1'b1;
                climate_t0 = tick.now_ms;
            end
            else if (hold_elapsed(tick.now_ms, climate_t0)) begin
                ctrl_state.climate_alarm = 1'b1;
            end
        end
        else begin
            climate_on = 1'b0;
            ctrl_state.climate_alarm = 1'b0;
        end

        if (is_day) begin
            // Sustained bright light opens the curtain.
            if (tick.light > cfg.light_level) begin
                if (!bright_on) begin
                    bright_on = 1'b1;
                    bright_t0 = tick.now_ms;
                end
                else if (hold_elapsed(tick.now_ms, bright_t0)) begin
                    ctrl_state.motor_open = 1'b1;
                    dark_on = 1'b0;
                end
            end
            else begin
                bright_on = 1'b0;
            end
            // Sustained darkness closes it.
            if (tick.light < cfg.light_level) begin
                if (!dark_on) begin
                    dark_on = 1'b1;
                    dark_t0 = tick.now_ms;
                end
                else if (hold_elapsed(tick.now_ms, dark_t0)) begin
                    ctrl_state.motor_open = 1'b0;
                    bright_on = 1'b0;
                end
            end
            else begin
                dark_on = 1'b0;
            end
        end
        else begin
            // At night the lamp follows darkness and the motor is left alone.
            ctrl_state.night_lamp = tick.light < cfg.light_level;
            bright_on = 1'b0;
            dark_on = 1'b0;
        end
        res = ctrl_state;
    endtask

    task automatic check_field(input string name, input logic want_bit, input logic got_bit);
        if (want_bit !== got_bit) begin
            $error("%s mismatch: expected %0b, actual %0b", name, want_bit, got_bit);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg.temp_high   = TEMP_HIGH_RST;
            cfg.temp_low    = TEMP_LOW_RST;
            cfg.humid_high  = HUMID_HIGH_RST;
            cfg.humid_low   = HUMID_LOW_RST;
            cfg.light_level = LIGHT_LEVEL_RST;
            cfg.hold_ms     = HOLD_MS_RST;
            climate_t0 = '0;
            bright_t0  = '0;
            dark_t0    = '0;
            climate_on = 1'b0;
            bright_on  = 1'b0;
            dark_on    = 1'b0;
            ctrl_state = '0;
            expected_outputs.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            // Register writes; unknown indexes are ignored.
            if (wr_en) begin
                case (wr_index)
                    CFG_TEMP_HIGH:   cfg.temp_high   = wr_data[7:0];
                    CFG_TEMP_LOW:    cfg.temp_low    = wr_data[7:0];
                    CFG_HUMID_HIGH:  cfg.humid_high  = wr_data[6:0];
                    CFG_HUMID_LOW:   cfg.humid_low   = wr_data[6:0];
                    CFG_LIGHT_LEVEL: cfg.light_level = wr_data;
                    CFG_HOLD_MS:     cfg.hold_ms     = wr_data;
                    default: ;
                endcase
            end

            // Each accepted tick yields exactly one result.
            if (in_valid && in_ready) begin
                seen_tick.now_ms      = now_ms;
                seen_tick.hour        = hour;
                seen_tick.temperature = temperature;
                seen_tick.humidity    = humidity;
                seen_tick.light       = light;
                advance_controller(seen_tick, predicted);
                expected_outputs.push_back(predicted);
            end

            // Compare each accepted result with the oldest prediction.
            if (out_valid && out_ready) begin
                observed.night_lamp    = night_lamp;
                observed.climate_alarm = climate_alarm;
                observed.motor_open    = motor_open;
                if (expected_outputs.size() == 0) begin
                    $error("unexpected result item: lamp %0b alarm %0b motor %0b",
                           night_lamp, climate_alarm, motor_open);
                    fail_count = fail_count + 1;
                end
                else begin
                    wanted = expected_outputs.pop_front();
                    check_field("night_lamp", wanted.night_lamp, observed.night_lamp);
                    check_field("climate_alarm", wanted.climate_alarm, observed.climate_alarm);
                    check_field("motor_open", wanted.motor_open, observed.motor_open);
                end
            end
            pending = expected_outputs.size();
        end
    end

endmodule

@@ sim/tb_sustained_threshold_light_climate_ctrl.sv @@
// Testbench top for the sustained-threshold light and climate controller.
// Drives directed and random control ticks under several configurations with random idling.
// Depends on stlc_pkg, the controller RTL and stlc_result_checker.
`timescale 1ns / 1ps

module tb_sustained_threshold_light_climate_ctrl;
    import stlc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    typedef enum logic [1:0] {LIGHT_BRIGHT, LIGHT_DARK, LIGHT_EQUAL} light_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          now_ms;
    logic [4:0]           hour;
    logic signed [7:0]    temperature;
    logic [6:0]           humidity;
    logic [15:0]          light;
    logic                 out_valid;
    logic                 out_ready;
    logic                 night_lamp;
    logic                 climate_alarm;
    logic                 motor_open;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [15:0]          wr_data;

    int unsigned          fail_count;
    int unsigned          pending;

    // Stimulus state: configuration as last written, clock of the ticks, modes.
    int                   t_hi;
    int                   t_lo;
    int                   h_hi;
    int                   h_lo;
    int                   lvl;
    int                   hold_cur;
    logic [31:0]          tick_clock;
    logic                 climate_bad;
    light_mode_t          light_mode;
    logic                 quiet;

    sustained_threshold_light_climate_ctrl DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .hour          (hour),
        .temperature   (temperature),
        .humidity      (humidity),
        .light         (light),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .night_lamp    (night_lamp),
        .climate_alarm (climate_alarm),
        .motor_open    (motor_open),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    stlc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .hour          (hour),
        .temperature   (temperature),
        .humidity      (humidity),
        .light         (light),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .night_lamp    (night_lamp),
        .climate_alarm (climate_alarm),
        .motor_open    (motor_open),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Uniform integer in [lo, hi].
    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Offer one tick after a random gap and hold it until it is accepted.
    task automatic send_tick(input logic [31:0] t_now, input int hr, input int tmp,
                             input int hum, input int lt);
        int gap;
        gap = quiet ? 0 : pick(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        now_ms      <= t_now;
        hour        <= 5'(hr);
        temperature <= 8'(tmp);
        humidity    <= 7'(hum);
        light       <= 16'(lt);
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Write all registers; spare upper data bits are random to check masking.
    task automatic set_config(input int thi, input int tlo, input int hhi, input int hlo,
                              input int lvl_v, input int hold_v);
        t_hi = thi;
        t_lo = tlo;
        h_hi = hhi;
        h_lo = hlo;
        lvl = lvl_v;
        hold_cur = hold_v;
        write_reg(CFG_TEMP_HIGH, {8'($urandom), 8'(thi)});
        write_reg(CFG_TEMP_LOW, {8'($urandom), 8'(tlo)});
        write_reg(CFG_HUMID_HIGH, {9'($urandom), 7'(hhi)});
        write_reg(CFG_HUMID_LOW, {9'($urandom), 7'(hlo)});
        write_reg(CFG_LIGHT_LEVEL, 16'(lvl_v));
        write_reg(CFG_HOLD_MS, 16'(hold_v));
        write_reg(CFG_UNUSED_6, 16'($urandom));
        write_reg(CFG_UNUSED_7, 16'($urandom));
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One random tick: mostly a sustained climate and light pattern, some noise.
    task automatic random_tick();
        int sel;
        int hr;
        int tmp;
        int hum;
        int lt;
        if ($urandom_range(9) == 0) climate_bad = ~climate_bad;
        if ($urandom_range(11) == 0) begin
            sel = pick(0, 9);
            light_mode = (sel == 0) ? LIGHT_EQUAL : (sel < 5) ? LIGHT_BRIGHT : LIGHT_DARK;
        end

        // Advance the tick clock, usually by a fraction of the hold time.
        sel = pick(0, 99);
        if (sel < 80)
            tick_clock = tick_clock + 32'(pick(0, hold_cur / 2 + 3));
        else if (sel < 90)
            tick_clock = tick_clock + 32'(pick(0, 3));
        else if (sel < 97)
            tick_clock = tick_clock + 32'(hold_cur - pick(0, 1));
        else
            tick_clock = $urandom;

        hr = ($urandom_range(9) < 8) ? pick(6, 17) : pick(0, 31);

        if ($urandom_range(9) == 0) begin
            tmp = pick(-128, 127);
            hum = pick(0, 127);
            lt = pick(0, 65535);
        end
        else begin
            tmp = (t_lo <= t_hi) ? pick(t_lo, t_hi) : pick(-128, 127);
            hum = (h_lo <= h_hi) ? pick(h_lo, h_hi) : pick(0, 127);
            if (climate_bad) begin
                case (pick(0, 3))
                    0: if (t_hi < 127) tmp = pick(t_hi + 1, 127);
                    1: if (t_lo > -128) tmp = pick(-128, t_lo - 1);
                    2: if (h_hi < 127) hum = pick(h_hi + 1, 127);
                    default: if (h_lo > 0) hum = pick(0, h_lo - 1);
                endcase
            end
            case (light_mode)
                LIGHT_BRIGHT: lt = (lvl < 65535) ? pick(lvl + 1, 65535) : lvl;
                LIGHT_DARK:   lt = (lvl > 0) ? pick(0, lvl - 1) : lvl;
                default:      lt = lvl;
            endcase
        end
        send_tick(tick_clock, hr, tmp, hum, lt);
    endtask

    // A random phase; halfway through, the sender waits for all results.
    task automatic run_random(input int count, input logic quiet_v);
        quiet = quiet_v;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain();
            random_tick();
        end
        drain();
    endtask

    // Result side: a random stall before each result item, none in quiet phases.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : pick(0, 12);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        int a;
        int b;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        now_ms      = '0;
        hour        = '0;
        temperature = '0;
        humidity    = '0;
        light       = '0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        quiet       = 1'b0;
        climate_bad = 1'b0;
        light_mode  = LIGHT_BRIGHT;
        t_hi = 35;
        t_lo = 10;
        h_hi = 80;
        h_lo = 20;
        lvl = 500;
        hold_cur = 2000;
        tick_clock = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset configuration.
        send_tick(32'd0, 12, 25, 50, 500);          // all in range, light at threshold
        send_tick(32'd0, 12, 40, 50, 600);          // climate and bright timers start at time 0
        send_tick(32'd1999, 12, 40, 50, 600);       // one ms short of the hold time
        send_tick(32'd2000, 12, 40, 50, 600);       // alarm on, curtain opens
        send_tick(32'd2500, 12, 25, 50, 500);       // back in range, light equal clears timers
        send_tick(32'd3000, 12, 25, 50, 100);       // darkness starts
        send_tick(32'd5000, 12, 25, 50, 100);       // curtain closes
        send_tick(32'd5100, 20, 25, 50, 100);       // night, lamp on
        send_tick(32'd5200, 20, 25, 50, 900);       // night, lamp off
        send_tick(32'd5300, 24, 25, 50, 0);         // hour past 23 counts as night
        send_tick(32'd5400, 31, -128, 0, 65535);    // field extremes at night
        send_tick(32'd5500, 5, 127, 127, 0);        // last night hour before day
        send_tick(32'd5600, 17, 25, 19, 65535);     // last day hour, humidity too low
        send_tick(32'd5700, 18, 25, 81, 65535);     // first night hour, humidity too high
        send_tick(32'hFFFF_F830, 6, 9, 50, 65535);  // first day hour, near the wrap
        send_tick(32'hFFFF_FFFF, 6, 36, 50, 65535); // 1999 ms in, at the top of the time range
        send_tick(32'd0, 6, 36, 50, 65535);         // hold reached across the wrap
        send_tick(32'd0, 11, 25, 50, 0);            // darkness first seen at time 0
        send_tick(32'd2000, 11, 25, 50, 0);         // curtain closes
        drain();

        // Random phases over a spread of configurations, extremes included.
        set_config(35, 10, 80, 20, 500, 50);
        run_random(200, 1'b0);
        set_config(127, -128, 100, 0, 0, 0);
        run_random(150, 1'b0);
        set_config(-128, 127, 0, 100, 65535, 3);
        run_random(120, 1'b0);
        set_config(20, 20, 50, 50, 1000, 200);
        run_random(200, 1'b1);
        tick_clock = 32'hFFFF_0000;
        set_config(127, -128, 127, 0, 300, 65535);
        run_random(120, 1'b0);
        for (int p = 0; p < 3; p++) begin
            a = pick(-128, 127);
            b = pick(-128, 127);
            t_lo = (a < b) ? a : b;
            t_hi = (a < b) ? b : a;
            a = pick(0, 100);
            b = pick(0, 100);
            set_config(t_hi, t_lo, (a < b) ? b : a, (a < b) ? a : b,
                       pick(0, 65535), pick(0, 300));
            tick_clock = $urandom;
            run_random(130, p == 1);
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/stlc_pkg.sv
src/stlc_core.sv
src/sustained_threshold_light_climate_ctrl.sv
sim/stlc_result_checker.sv
sim/tb_sustained_threshold_light_climate_ctrl.sv
